FILE: rtl/core/kplr_pkg.sv
package kplr_pkg;

    localparam int KEY_INPUTS  = 6;
    localparam int TICK_W      = 16;
    localparam int ELAPSED_W   = 8;
    localparam int POT_W       = 16;
    localparam int EVENT_W     = 4;
    localparam int IVL_W       = 8;
    localparam int ADD_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MOD_STEPS   = 16;
    localparam int MOD_CNT_W   = 4;

    // elapsed / 10 == (elapsed * 205) >> 11 for every 8-bit elapsed value.
    localparam logic [ELAPSED_W-1:0] DIV10_MUL   = 8'd205;
    localparam int                   DIV10_SHIFT = 11;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic [EVENT_W-1:0] EV_NONE = 4'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_PRESS_ENABLE     = 3'd0,
        CFG_MIN_PRESS_TICKS       = 3'd1,
        CFG_LONG_PRESS_TICKS      = 3'd2,
        CFG_REPEAT_START_TICKS    = 3'd3,
        CFG_REPEAT_INTERVAL_TICKS = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_RELEASED = 2'd0,
        MODE_PRESSED  = 2'd1,
        MODE_REPEAT   = 2'd2,
        MODE_WAIT     = 2'd3
    } key_mode_t;

    typedef struct packed {
        key_mode_t           mode;
        logic [TICK_W-1:0]   ticks;
    } key_ent_t;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b0000000001,
        ST_KRD  = 10'b0000000010,
        ST_KLD  = 10'b0000000100,
        ST_KEXE = 10'b0000001000,
        ST_KMOD = 10'b0000010000,
        ST_KFIN = 10'b0000100000,
        ST_POT  = 10'b0001000000,
        ST_RRD  = 10'b0010000000,
        ST_RDAT = 10'b0100000000,
        ST_DONE = 10'b1000000000
    } seq_state_t;

endpackage

FILE: rtl/core/kplr_req_if.sv
interface kplr_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [kplr_pkg::ELAPSED_W-1:0]      elapsed_time;
    logic [kplr_pkg::KEY_INPUTS-1:0]     keys_pressed;
    logic signed [kplr_pkg::POT_W-1:0]   pot_value;

    modport source (
        output valid, req_type, elapsed_time, keys_pressed, pot_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, elapsed_time, keys_pressed, pot_value,
        output ready
    );
endinterface

FILE: rtl/core/kplr_rsp_if.sv
interface kplr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [kplr_pkg::EVENT_W-1:0]   event_code;
    logic                           queue_empty;

    modport source (
        output valid, event_code, queue_empty,
        input  ready
    );
    modport sink (
        input  valid, event_code, queue_empty,
        output ready
    );
endinterface

FILE: rtl/core/kplr_cfg_if.sv
interface kplr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [kplr_pkg::CFG_IDX_W-1:0]    index;
    logic [kplr_pkg::CFG_DATA_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/core/keypad_press_long_repeat_events.sv
// A tick item runs each key through the read, load and execute states, then the
// pot and done states; a held repeat-mode key with a nonzero interval also runs
// the bit-serial remainder unit (one quotient bit per cycle) and a finish state.
// A read item runs the ring read and data states, or just done on an empty ring.
// One item is in work at a time; each key reads and writes the key-state memory.
// Reset clears control state and memory valid bits; no clearing pass is needed.
module keypad_press_long_repeat_events #(
    parameter int NUM_KEYS   = 6,
    parameter int RING_DEPTH = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    kplr_req_if.sink    req,
    kplr_rsp_if.source  rsp,
    kplr_cfg_if.sink    cfg
);

    localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int RING_W = $clog2(RING_DEPTH);
    localparam logic [KEY_W-1:0]  KEY_LAST  = KEY_W'(NUM_KEYS - 1);
    localparam logic [RING_W-1:0] RING_LAST = RING_W'(RING_DEPTH - 1);
    localparam logic [kplr_pkg::EVENT_W-1:0] POT_CODE =
        kplr_pkg::EVENT_W'(2 * NUM_KEYS + 1);

    // Configuration registers.
    logic                              lpe_reg;
    logic [kplr_pkg::TICK_W-1:0]       min_reg;
    logic [kplr_pkg::TICK_W-1:0]       long_reg;
    logic [kplr_pkg::TICK_W-1:0]       rstart_reg;
    logic [kplr_pkg::IVL_W-1:0]        ivl_reg;

    // Latched item.
    logic                              type_reg;
    logic [kplr_pkg::ADD_W-1:0]        add_reg;
    logic [kplr_pkg::KEY_INPUTS-1:0]   keys_reg;
    logic [kplr_pkg::POT_W-1:0]        pot_reg;
    logic [2*kplr_pkg::ELAPSED_W-1:0]  div_prod;

    kplr_pkg::seq_state_t              state_reg, state_next;
    logic [KEY_W-1:0]                  k_reg, k_next;
    logic [kplr_pkg::TICK_W-1:0]       t_reg, t_next;
    kplr_pkg::key_mode_t               mode_reg, mode_next;
    logic                              down_reg, down_next;
    logic [kplr_pkg::TICK_W-1:0]       dvd_reg, dvd_next;
    logic [kplr_pkg::IVL_W-1:0]        rem_reg, rem_next;
    logic [kplr_pkg::IVL_W:0]          rem_tmp;
    logic [kplr_pkg::MOD_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [kplr_pkg::EVENT_W-1:0]      res_code_reg, res_code_next;
    logic                              res_empty_reg, res_empty_next;
    logic                              out_vld_reg, out_vld_next;
    logic [kplr_pkg::EVENT_W-1:0]      out_code_reg, out_code_next;
    logic                              out_empty_reg, out_empty_next;
    logic [RING_W-1:0]                 wr_reg, wr_next, wr_inc;
    logic [RING_W-1:0]                 rd_reg, rd_next, rd_inc;
    logic [kplr_pkg::POT_W-1:0]        last_pot_reg, last_pot_next;

    // Key-state memory with a valid bit per entry; an invalid entry reads as released.
    kplr_pkg::key_ent_t                key_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]               key_vld_reg;
    kplr_pkg::key_ent_t                key_rd_reg;
    logic                              key_rvld_reg;
    logic                              key_we, key_re;
    kplr_pkg::key_ent_t                key_wdata;

    // Event ring memory; an invalid entry reads as no event.
    logic [kplr_pkg::EVENT_W-1:0]      ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]             ring_vld_reg;
    logic [kplr_pkg::EVENT_W-1:0]      ring_rd_reg;
    logic                              ring_rvld_reg;
    logic                              ring_we, ring_re;
    logic [RING_W-1:0]                 ring_waddr;
    logic [kplr_pkg::EVENT_W-1:0]      ring_wdata;

    logic                              in_acc;
    logic [7:0]                        keys_ext;
    logic [2:0]                        k3;
    logic [kplr_pkg::EVENT_W-1:0]      short_code, long_code;

    assign req.ready      = (state_reg == kplr_pkg::ST_IDLE);
    assign in_acc         = req.valid && req.ready;
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_vld_reg;
    assign rsp.event_code = out_code_reg;
    assign rsp.queue_empty = out_empty_reg;

    assign div_prod   = req.elapsed_time * kplr_pkg::DIV10_MUL;
    assign wr_inc     = (wr_reg == RING_LAST) ? '0 : wr_reg + 1'b1;
    assign rd_inc     = (rd_reg == RING_LAST) ? '0 : rd_reg + 1'b1;
    assign keys_ext   = {2'b00, keys_reg};
    assign k3         = 3'(k_reg);
    assign short_code = kplr_pkg::EVENT_W'(int'(k_reg) + 1);
    assign long_code  = kplr_pkg::EVENT_W'(int'(k_reg) + 1 + NUM_KEYS);
    assign rem_tmp    = {rem_reg, dvd_reg[kplr_pkg::TICK_W-1]};

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        mode_next      = mode_reg;
        down_next      = down_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        res_code_next  = res_code_reg;
        res_empty_next = res_empty_reg;
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        last_pot_next  = last_pot_reg;
        out_vld_next   = out_vld_reg && !rsp.ready;
        out_code_next  = out_code_reg;
        out_empty_next = out_empty_reg;
        key_we         = 1'b0;
        key_re         = 1'b0;
        key_wdata      = '{mode: mode_reg, ticks: t_reg};
        ring_we        = 1'b0;
        ring_re        = 1'b0;
        ring_waddr     = wr_reg;
        ring_wdata     = kplr_pkg::EV_NONE;

        case (state_reg)
            kplr_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    res_code_next  = kplr_pkg::EV_NONE;
                    res_empty_next = 1'b0;
                    if (req.req_type == kplr_pkg::REQ_TICK)
                    begin
                        k_next     = '0;
                        state_next = kplr_pkg::ST_KRD;
                    end
                    else if (rd_reg == wr_reg)
                    begin
                        res_empty_next = 1'b1;
                        state_next     = kplr_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = kplr_pkg::ST_RRD;
                    end
                end
            end
            kplr_pkg::ST_KRD:
            begin
                key_re     = 1'b1;
                state_next = kplr_pkg::ST_KLD;
            end
            kplr_pkg::ST_KLD:
            begin
                mode_next  = key_rvld_reg ? key_rd_reg.mode : kplr_pkg::MODE_RELEASED;
                t_next     = (key_rvld_reg ? key_rd_reg.ticks : '0)
                             + kplr_pkg::TICK_W'(add_reg);
                down_next  = keys_ext[k3];
                state_next = kplr_pkg::ST_KEXE;
            end
            kplr_pkg::ST_KEXE:
            begin
                key_we = 1'b1;
                case (mode_reg)
                    kplr_pkg::MODE_RELEASED:
                    begin
                        if (down_reg && t_reg >= min_reg)
                        begin
                            key_wdata = '{mode: kplr_pkg::MODE_PRESSED, ticks: '0};
                        end
                    end
                    kplr_pkg::MODE_PRESSED:
                    begin
                        if (down_reg)
                        begin
                            if (lpe_reg && t_reg >= long_reg)
                            begin
                                ring_we    = 1'b1;
                                ring_wdata = long_code;
                                key_wdata  = '{mode: kplr_pkg::MODE_WAIT, ticks: '0};
                            end
                            else if (!lpe_reg && t_reg >= rstart_reg)
                            begin
                                ring_we    = 1'b1;
                                ring_wdata = short_code;
                                key_wdata  = '{mode: kplr_pkg::MODE_REPEAT, ticks: t_reg};
                            end
                        end
                        else
                        begin
                            ring_we    = (t_reg >= min_reg);
                            ring_wdata = short_code;
                            key_wdata  = '{mode: kplr_pkg::MODE_RELEASED, ticks: '0};
                        end
                    end
                    kplr_pkg::MODE_REPEAT:
                    begin
                        if (!down_reg)
                        begin
                            key_wdata = '{mode: kplr_pkg::MODE_RELEASED, ticks: '0};
                        end
                    end
                    default:
                    begin
                        if (!down_reg)
                        begin
                            key_wdata = '{mode: kplr_pkg::MODE_RELEASED, ticks: '0};
                        end
                    end
                endcase
                if (ring_we)
                begin
                    wr_next = wr_inc;
                end
                // A held key in repeat mode needs ticks modulo the interval.
                if (mode_reg == kplr_pkg::MODE_REPEAT && down_reg && ivl_reg != '0)
                begin
                    dvd_next   = t_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = kplr_pkg::ST_KMOD;
                end
                else if (k_reg == KEY_LAST)
                begin
                    state_next = kplr_pkg::ST_POT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = kplr_pkg::ST_KRD;
                end
            end
            kplr_pkg::ST_KMOD:
            begin
                if (rem_tmp >= {1'b0, ivl_reg})
                begin
                    rem_next = kplr_pkg::IVL_W'(rem_tmp - {1'b0, ivl_reg});
                end
                else
                begin
                    rem_next = rem_tmp[kplr_pkg::IVL_W-1:0];
                end
                dvd_next = {dvd_reg[kplr_pkg::TICK_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == kplr_pkg::MOD_CNT_W'(kplr_pkg::MOD_STEPS - 1))
                begin
                    state_next = kplr_pkg::ST_KFIN;
                end
            end
            kplr_pkg::ST_KFIN:
            begin
                if (rem_reg == '0)
                begin
                    ring_we    = 1'b1;
                    ring_wdata = short_code;
                    wr_next    = wr_inc;
                end
                if (k_reg == KEY_LAST)
                begin
                    state_next = kplr_pkg::ST_POT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = kplr_pkg::ST_KRD;
                end
            end
            kplr_pkg::ST_POT:
            begin
                if (pot_reg != last_pot_reg)
                begin
                    ring_we    = 1'b1;
                    ring_wdata = POT_CODE;
                    wr_next    = wr_inc;
                end
                last_pot_next = pot_reg;
                state_next    = kplr_pkg::ST_DONE;
            end
            kplr_pkg::ST_RRD:
            begin
                ring_re    = 1'b1;
                state_next = kplr_pkg::ST_RDAT;
            end
            kplr_pkg::ST_RDAT:
            begin
                res_code_next = ring_rvld_reg ? ring_rd_reg : kplr_pkg::EV_NONE;
                // The popped entry is cleared to no event.
                ring_we    = 1'b1;
                ring_waddr = rd_reg;
                ring_wdata = kplr_pkg::EV_NONE;
                rd_next    = rd_inc;
                state_next = kplr_pkg::ST_DONE;
            end
            kplr_pkg::ST_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next   = 1'b1;
                    out_code_next  = res_code_reg;
                    out_empty_next = res_empty_reg;
                    state_next     = kplr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kplr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kplr_pkg::ST_IDLE;
            k_reg        <= '0;
            cnt_reg      <= '0;
            out_vld_reg  <= 1'b0;
            wr_reg       <= '0;
            rd_reg       <= '0;
            last_pot_reg <= '0;
            key_vld_reg  <= '0;
            ring_vld_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            cnt_reg      <= cnt_next;
            out_vld_reg  <= out_vld_next;
            wr_reg       <= wr_next;
            rd_reg       <= rd_next;
            last_pot_reg <= last_pot_next;
            if (key_we)
            begin
                key_vld_reg[k_reg] <= 1'b1;
            end
            if (ring_we)
            begin
                ring_vld_reg[ring_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpe_reg    <= 1'b1;
            min_reg    <= 16'd10;
            long_reg   <= 16'd100;
            rstart_reg <= 16'd40;
            ivl_reg    <= 8'd30;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                kplr_pkg::CFG_LONG_PRESS_ENABLE:     lpe_reg    <= cfg.data[0];
                kplr_pkg::CFG_MIN_PRESS_TICKS:       min_reg    <= cfg.data;
                kplr_pkg::CFG_LONG_PRESS_TICKS:      long_reg   <= cfg.data;
                kplr_pkg::CFG_REPEAT_START_TICKS:    rstart_reg <= cfg.data;
                kplr_pkg::CFG_REPEAT_INTERVAL_TICKS: ivl_reg    <= cfg.data[kplr_pkg::IVL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            type_reg <= req.req_type;
            add_reg  <= div_prod[kplr_pkg::DIV10_SHIFT +: kplr_pkg::ADD_W];
            keys_reg <= req.keys_pressed;
            pot_reg  <= req.pot_value;
        end
        t_reg         <= t_next;
        mode_reg      <= mode_next;
        down_reg      <= down_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        res_code_reg  <= res_code_next;
        res_empty_reg <= res_empty_next;
        out_code_reg  <= out_code_next;
        out_empty_reg <= out_empty_next;
    end

    // Key-state memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[k_reg] <= key_wdata;
        end
        if (key_re)
        begin
            key_rd_reg   <= key_mem[k_reg];
            key_rvld_reg <= key_vld_reg[k_reg];
        end
    end

    // Event ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_rd_reg   <= ring_mem[rd_reg];
            ring_rvld_reg <= ring_vld_reg[rd_reg];
        end
    end

    // The key walk never runs past the last key.
    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= KEY_LAST)
        else $error("key index out of range");

    // Both ring pointers stay inside the ring.
    a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_reg <= RING_LAST) && (rd_reg <= RING_LAST))
        else $error("ring pointer out of range");

    // A pop read and an event write never share a cycle.
    a_ring_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ring_we && ring_re))
        else $error("ring read and write collide");

    // A new result only appears after the sequencer finished an item.
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == kplr_pkg::ST_DONE))
        else $error("result raised outside completion");

    // The item type latched at acceptance decides the path taken.
    a_tick_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kplr_pkg::ST_KRD || state_reg == kplr_pkg::ST_POT)
        |-> (type_reg == kplr_pkg::REQ_TICK))
        else $error("key walk on a read item");

endmodule
